// ===== rtl/trbs_pkg.sv =====
package trbs_pkg;

	// Ring geometry.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TIME_W   = 32;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_STORED  = 3'd0,
		STAT_DROPPED = 3'd1,
		STAT_BRACKET = 3'd2,
		STAT_SINGLE  = 3'd3,
		STAT_EMPTY   = 3'd4,
		STAT_RANGE   = 3'd5
	} status_t;

	// Operation decoded by the front.
	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Sequencer states of the back.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_QOLD,
		S_QNEW,
		S_SRCH,
		S_DONE
	} state_t;

	// Incoming request as seen on the port.
	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] time_value;
	} in_item_t;

	// Classified request held in the queue.
	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] time_value;
	} req_t;

	// Result as seen on the port.
	typedef struct packed {
		logic [2:0]        status;
		logic [IDX_W-1:0]  write_slot;
		logic [IDX_W-1:0]  lower_slot;
		logic [IDX_W-1:0]  upper_slot;
		logic [TIME_W-1:0] lower_time;
		logic [TIME_W-1:0] upper_time;
		logic [CNT_W-1:0]  entry_count;
		logic [IDX_W-1:0]  newest_slot;
	} out_item_t;

	// Handshake between the queue and the back.
	typedef struct packed {
		logic valid;
		req_t head;
	} queue_out_t;

	// Handshake between the front and the queue.
	typedef struct packed {
		logic valid;
		req_t data;
	} front_out_t;

endpackage

// ===== rtl/trbs_front.sv =====
module trbs_front
	import trbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  in_item_t   req_data,
	output front_out_t front,
	input  logic       queue_full
);

	logic front_valid_q;
	req_t front_data_q;

	// The front register holds while the queue cannot take its request.
	assign req_stall = front_valid_q && queue_full;

	// Register the request and decode its operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (!req_stall) begin
			front_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			front_data_q.op         <= req_data.mode ? OP_QUERY : OP_PUSH;
			front_data_q.time_value <= req_data.time_value;
		end
	end

	assign front.valid = front_valid_q;
	assign front.data  = front_data_q;

endmodule

// ===== rtl/trbs_queue.sv =====
module trbs_queue
	import trbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  front_out_t front,
	output logic       full,
	input  logic       pop,
	output queue_out_t qout
);

	req_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	logic              do_pop;

	assign full   = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign push   = front.valid && !full;
	assign do_pop = pop && (fill_q != '0);

	// Pointer increment with wrap at the queue depth.
	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_W'(1);
		end
		return r;
	endfunction

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= front.data;
		end
	end

	assign qout.valid = (fill_q != '0);
	assign qout.head  = entry_q[rd_ptr_q];

endmodule

// ===== rtl/trbs_back.sv =====
module trbs_back
	import trbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  queue_out_t qout,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output out_item_t  rsp_data
);

	// Timestamp memory, one write and one registered read port.
	logic [TIME_W-1:0] mem [CAPACITY];
	logic [TIME_W-1:0] rdata_q;

	state_t            state_q, state_d;
	req_t              item_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [IDX_W-1:0]  lo_q, hi_q;
	logic [TIME_W-1:0] lo_time_q, hi_time_q;
	logic              res_valid_q;
	out_item_t         res_q;

	// Control decoded from the state.
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic              cnt_inc;
	logic              old_adv;
	logic              search_ld;
	logic [IDX_W-1:0]  lo_d, hi_d;
	logic [TIME_W-1:0] lo_time_d, hi_time_d;
	logic              finish;
	out_item_t         res_d;

	// Shared decisions.
	logic              out_free;
	logic [IDX_W-1:0]  newest_cur;
	logic              drop;
	logic              out_range;
	logic              qnew_final;
	logic [IDX_W-1:0]  mid_cur;
	logic [IDX_W-1:0]  sr_lo, sr_hi;
	logic [TIME_W-1:0] sr_lo_time, sr_hi_time;
	logic              sr_more;
	logic [IDX_W-1:0]  top_idx;

	// Logical index to physical slot, wrapping at the capacity.
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
	                                           input logic [IDX_W-1:0] logical);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, logical};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Midpoint of a search interval.
	function automatic logic [IDX_W-1:0] midpoint(input logic [IDX_W-1:0] lo,
	                                               input logic [IDX_W-1:0] hi);
		logic [IDX_W-1:0] span;
		span = hi - lo;
		return lo + (span >> 1);
	endfunction

	// True while the interval still has a point between its ends.
	function automatic logic open_gap(input logic [IDX_W-1:0] lo,
	                                  input logic [IDX_W-1:0] hi);
		return (({1'b0, lo} + (IDX_W+1)'(1)) < {1'b0, hi});
	endfunction

	assign out_free   = !res_valid_q || !rsp_stall;
	assign top_idx    = IDX_W'(count_q - CNT_W'(1));
	assign newest_cur = phys(oldest_q, top_idx);
	assign drop       = (count_q != '0) && (item_q.time_value <= rdata_q);
	assign out_range  = (item_q.time_value < lo_time_q) || (item_q.time_value > rdata_q);
	assign qnew_final = out_range || (count_q <= CNT_W'(2));

	// One halving step of the search, using the midpoint time just read.
	always_comb begin
		mid_cur    = midpoint(lo_q, hi_q);
		sr_lo      = lo_q;
		sr_hi      = hi_q;
		sr_lo_time = lo_time_q;
		sr_hi_time = hi_time_q;
		if (rdata_q <= item_q.time_value) begin
			sr_lo      = mid_cur;
			sr_lo_time = rdata_q;
		end else begin
			sr_hi      = mid_cur;
			sr_hi_time = rdata_q;
		end
		sr_more = open_gap(sr_lo, sr_hi);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (qout.valid) begin
					state_d = (qout.head.op == OP_PUSH) ? S_PUSH : S_QOLD;
				end
			end
			S_PUSH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_QOLD: begin
				if (count_q != '0) begin
					state_d = S_QNEW;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_QNEW: begin
				if (!qnew_final) begin
					state_d = S_SRCH;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SRCH: begin
				state_d = sr_more ? S_SRCH : S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control and result assembly for each state.
	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		we        = 1'b0;
		waddr     = '0;
		cnt_inc   = 1'b0;
		old_adv   = 1'b0;
		search_ld = 1'b0;
		lo_d      = lo_q;
		hi_d      = hi_q;
		lo_time_d = lo_time_q;
		hi_time_d = hi_time_q;
		finish    = 1'b0;
		res_d     = '0;
		res_d.entry_count = count_q;
		res_d.newest_slot = (count_q != '0) ? newest_cur : '0;
		case (state_q)
			S_IDLE: begin
				if (qout.valid) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					rd_addr = (qout.head.op == OP_PUSH) ? newest_cur : oldest_q;
				end
			end
			S_PUSH: begin
				if (out_free) begin
					finish = 1'b1;
					if (drop) begin
						res_d.status = STAT_DROPPED;
					end else begin
						we = 1'b1;
						if (count_q < CNT_W'(CAPACITY)) begin
							waddr   = phys(oldest_q, IDX_W'(count_q));
							cnt_inc = 1'b1;
							res_d.entry_count = count_q + CNT_W'(1);
						end else begin
							waddr   = oldest_q;
							old_adv = 1'b1;
						end
						res_d.status      = STAT_STORED;
						res_d.write_slot  = waddr;
						res_d.newest_slot = waddr;
					end
				end
			end
			S_QOLD: begin
				if (count_q == '0) begin
					if (out_free) begin
						finish       = 1'b1;
						res_d.status = STAT_EMPTY;
					end
				end else begin
					search_ld = 1'b1;
					lo_time_d = rdata_q;
					rd_en     = 1'b1;
					rd_addr   = newest_cur;
				end
			end
			S_QNEW: begin
				if (out_range) begin
					if (out_free) begin
						finish       = 1'b1;
						res_d.status = STAT_RANGE;
					end
				end else if (count_q == CNT_W'(1)) begin
					if (out_free) begin
						finish           = 1'b1;
						res_d.status     = STAT_SINGLE;
						res_d.lower_slot = oldest_q;
						res_d.upper_slot = oldest_q;
						res_d.lower_time = lo_time_q;
						res_d.upper_time = lo_time_q;
					end
				end else if (count_q == CNT_W'(2)) begin
					if (out_free) begin
						finish           = 1'b1;
						res_d.status     = STAT_BRACKET;
						res_d.lower_slot = oldest_q;
						res_d.upper_slot = newest_cur;
						res_d.lower_time = lo_time_q;
						res_d.upper_time = rdata_q;
					end
				end else begin
					search_ld = 1'b1;
					lo_d      = '0;
					hi_d      = top_idx;
					hi_time_d = rdata_q;
					rd_en     = 1'b1;
					rd_addr   = phys(oldest_q, midpoint('0, top_idx));
				end
			end
			S_SRCH: begin
				search_ld = 1'b1;
				lo_d      = sr_lo;
				hi_d      = sr_hi;
				lo_time_d = sr_lo_time;
				hi_time_d = sr_hi_time;
				if (sr_more) begin
					rd_en   = 1'b1;
					rd_addr = phys(oldest_q, midpoint(sr_lo, sr_hi));
				end
			end
			S_DONE: begin
				if (out_free) begin
					finish           = 1'b1;
					res_d.status     = STAT_BRACKET;
					res_d.lower_slot = phys(oldest_q, lo_q);
					res_d.upper_slot = phys(oldest_q, hi_q);
					res_d.lower_time = lo_time_q;
					res_d.upper_time = hi_time_q;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= item_q.time_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Control state: sequencer, ring pointers and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			oldest_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (old_adv) begin
				oldest_q <= phys(oldest_q, IDX_W'(1));
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current request and the result register.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= qout.head;
		end
		if (search_ld) begin
			lo_q      <= lo_d;
			hi_q      <= hi_d;
			lo_time_q <= lo_time_d;
			hi_time_q <= hi_time_d;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	assign rsp_valid = res_valid_q;
	assign rsp_data  = res_q;

endmodule

// ===== rtl/timestamp_ring_bracket_search.sv =====
// A push reads the newest timestamp, then stores or drops its time. A query on an empty
// ring reports it as empty; else it reads the oldest and then the newest timestamp and,
// when in range over three or more entries, halves the interval with one read per step.
// The back works on one request at a time; the queue keeps accepting requests while the
// back is busy or stalled, until it is full.
// Reset clears the pointers, the entry count and all valid flags; no clearing pass is run.
module timestamp_ring_bracket_search
	import trbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req_data,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp_data
);

	front_out_t front;
	queue_out_t qout;
	logic       queue_full;
	logic       pop;

	// Accept and classify requests.
	trbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.front      (front),
		.queue_full (queue_full)
	);

	// Decouple the front from the back.
	trbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.full   (queue_full),
		.pop    (pop),
		.qout   (qout)
	);

	// Ring storage, pushes and bracket search.
	trbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qout      (qout),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import trbs_pkg::*;

	localparam int IDLE_PCT      = 6;
	localparam int RANDOM_ITEMS  = 850;
	localparam int CALM_FIRST    = 300;
	localparam int CALM_LAST     = 500;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 30;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req_data  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp_data;

	// Stimulus flags for the stall process, the stall state and the mismatch count.
	logic calm      = 1'b0;
	logic hold_ask  = 1'b0;
	logic hold_ask_q = 1'b0;
	int   hold_left = 0;
	int   mismatches = 0;

	// Predicted ring contents, kept in step with accepted requests.
	logic [TIME_W-1:0] ring_time [CAPACITY];
	int                ring_oldest = 0;
	int                ring_count  = 0;
	out_item_t         due_results [$];

	timestamp_ring_bracket_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #2 clk = ~clk;

	// Maps a logical index (0 = oldest) onto a physical slot.
	function automatic int slot_of(input int logical);
		return (ring_oldest + logical) % CAPACITY;
	endfunction

	// Applies one request to the predicted ring and returns the result it should give.
	function automatic out_item_t ring_predict(input in_item_t req);
		out_item_t         r;
		int                lo, hi, mid, ws;
		logic [TIME_W-1:0] t;
		r = '0;
		t = req.time_value;
		if (op_t'(req.mode) == OP_PUSH) begin
			if (ring_count > 0 && t <= ring_time[slot_of(ring_count - 1)]) begin
				r.status = STAT_DROPPED;
			end else if (ring_count < CAPACITY) begin
				ws = slot_of(ring_count);
				ring_time[ws] = t;
				ring_count++;
				r.status = STAT_STORED;
				r.write_slot = IDX_W'(ws);
			end else begin
				ws = ring_oldest;
				ring_time[ws] = t;
				ring_oldest = (ws + 1) % CAPACITY;
				r.status = STAT_STORED;
				r.write_slot = IDX_W'(ws);
			end
		end else if (ring_count == 0) begin
			r.status = STAT_EMPTY;
		end else if (t < ring_time[slot_of(0)] || t > ring_time[slot_of(ring_count - 1)]) begin
			r.status = STAT_RANGE;
		end else if (ring_count == 1) begin
			r.status = STAT_SINGLE;
			r.lower_slot = IDX_W'(slot_of(0));
			r.upper_slot = r.lower_slot;
			r.lower_time = ring_time[slot_of(0)];
			r.upper_time = r.lower_time;
		end else begin
			// Halve until the pair brackets the render time.
			lo = 0;
			hi = ring_count - 1;
			while (lo + 1 < hi) begin
				mid = lo + (hi - lo) / 2;
				if (ring_time[slot_of(mid)] <= t)
					lo = mid;
				else
					hi = mid;
			end
			r.status = STAT_BRACKET;
			r.lower_slot = IDX_W'(slot_of(lo));
			r.upper_slot = IDX_W'(slot_of(hi));
			r.lower_time = ring_time[slot_of(lo)];
			r.upper_time = ring_time[slot_of(hi)];
		end
		r.entry_count = CNT_W'(ring_count);
		if (ring_count > 0)
			r.newest_slot = IDX_W'(slot_of(ring_count - 1));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Offers one request and waits until the block takes it.
	task automatic send_item(input op_t op, input logic [TIME_W-1:0] t);
		in_item_t it;
		it.mode = op;
		it.time_value = t;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due_results.push_back(ring_predict(it));
	endtask

	// The sender stops until every predicted result has been seen.
	task automatic wait_all_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// One random request, mostly well-formed pushes and in-range queries.
	task automatic send_random_item();
		int                pick;
		logic [TIME_W-1:0] oldest_t, newest_t, t;
		pick = $urandom_range(99);
		oldest_t = (ring_count > 0) ? ring_time[slot_of(0)] : '0;
		newest_t = (ring_count > 0) ? ring_time[slot_of(ring_count - 1)] : '0;
		if (ring_count == 0) begin
			send_item(OP_PUSH, $urandom_range(0, 1000));
		end else if (pick < 50) begin
			t = newest_t + (($urandom_range(9) == 0) ? 1 : $urandom_range(1, 1 << 22));
			send_item(OP_PUSH, t);
		end else if (pick < 62) begin
			t = ($urandom_range(1) == 0) ? newest_t : $urandom_range(0, newest_t);
			send_item(OP_PUSH, t);
		end else if (pick < 77) begin
			send_item(OP_QUERY, oldest_t + $urandom_range(0, newest_t - oldest_t));
		end else if (pick < 87) begin
			send_item(OP_QUERY, ring_time[slot_of($urandom_range(0, ring_count - 1))]);
		end else if (pick < 92) begin
			t = (oldest_t == 0) ? '0 : $urandom_range(0, oldest_t - 1);
			send_item(OP_QUERY, t);
		end else if (pick < 97) begin
			t = (newest_t == TIME_MAX) ? TIME_MAX : $urandom_range(newest_t + 1, TIME_MAX);
			send_item(OP_QUERY, t);
		end else begin
			send_item(OP_QUERY, $urandom);
		end
	endtask

	// Queries on a ring that holds nothing yet.
	task automatic test_empty_ring();
		send_item(OP_QUERY, '0);
		send_item(OP_QUERY, TIME_MAX);
	endtask

	// First push, drops, and queries with one, two and three entries.
	task automatic test_first_entries();
		send_item(OP_PUSH, '0);
		send_item(OP_PUSH, '0);
		send_item(OP_QUERY, '0);
		send_item(OP_QUERY, 32'd1);
		send_item(OP_PUSH, 32'd100);
		send_item(OP_PUSH, 32'd50);
		send_item(OP_QUERY, '0);
		send_item(OP_QUERY, 32'd100);
		send_item(OP_QUERY, 32'd70);
		send_item(OP_PUSH, 32'd200);
		send_item(OP_QUERY, 32'd100);
		send_item(OP_QUERY, 32'd201);
	endtask

	// Fills the ring until the oldest entry is overwritten, then probes the edges.
	task automatic test_ring_wrap();
		logic [TIME_W-1:0] t;
		for (int i = 0; i < 14; i++) begin
			t = ring_time[slot_of(ring_count - 1)] + ((i == 0) ? 1 : 1000 * i);
			send_item(OP_PUSH, t);
		end
		send_item(OP_QUERY, ring_time[slot_of(0)] - 1);
		send_item(OP_QUERY, ring_time[slot_of(0)]);
		send_item(OP_QUERY, ring_time[slot_of(ring_count - 1)]);
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		calm = 1'b1;
		hold_ask <= 1'b1;
		for (int i = 0; i < 12; i++)
			send_random_item();
		hold_ask <= 1'b0;
		calm = 1'b0;
	endtask

	// Random requests with a stretch in which neither side idles.
	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= CALM_FIRST && i < CALM_LAST);
			send_random_item();
		end
		calm = 1'b0;
	endtask

	// The largest time locks the ring, so this runs last.
	task automatic test_time_ceiling();
		send_item(OP_PUSH, TIME_MAX);
		send_item(OP_QUERY, TIME_MAX);
		send_item(OP_QUERY, TIME_MAX - 1);
		send_item(OP_PUSH, TIME_MAX);
		send_item(OP_PUSH, '0);
		send_item(OP_QUERY, '0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		wait_all_results();
		test_first_entries();
		wait_all_results();
		test_ring_wrap();
		wait_all_results();
		test_backpressure();
		wait_all_results();
		test_random_mix();
		wait_all_results();
		test_time_ceiling();
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("PASS timestamp_ring_bracket_search");
		else
			$display("FAIL timestamp_ring_bracket_search");
		$finish;
	end

	// Receiver stall: a long hold when asked, otherwise sparse random stalls.
	always @(posedge clk) begin
		hold_ask_q <= hold_ask;
		if (hold_ask && !hold_ask_q) begin
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Each accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result status", 32'(rsp_data.status), '0);
			end else begin
				want = due_results.pop_front();
				check_field("status", 32'(rsp_data.status), 32'(want.status));
				check_field("write_slot", 32'(rsp_data.write_slot), 32'(want.write_slot));
				check_field("lower_slot", 32'(rsp_data.lower_slot), 32'(want.lower_slot));
				check_field("upper_slot", 32'(rsp_data.upper_slot), 32'(want.upper_slot));
				check_field("lower_time", rsp_data.lower_time, want.lower_time);
				check_field("upper_time", rsp_data.upper_time, want.upper_time);
				check_field("entry_count", 32'(rsp_data.entry_count),
					32'(want.entry_count));
				check_field("newest_slot", 32'(rsp_data.newest_slot),
					32'(want.newest_slot));
			end
		end
	end

	// Ends the run when nothing has been accepted on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
		$display("FAIL timestamp_ring_bracket_search");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/trbs_pkg.sv
rtl/trbs_front.sv
rtl/trbs_queue.sv
rtl/trbs_back.sv
rtl/timestamp_ring_bracket_search.sv
tb/sv/tb_top.sv
